// ----- rtl/separable_linear_upscaler_assert.svh -----
// ----------------------------------------------------------------------------
// separable_linear_upscaler assertion macros
// concurrent checks, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_LINEAR_UPSCALER_ASSERT_SVH
`define SEPARABLE_LINEAR_UPSCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define SLU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("upscaler check failed");
`define SLU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("upscaler check failed");
`else
`define SLU_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SLU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/slu_pkg.sv -----
// ----------------------------------------------------------------------------
// slu_pkg
// shared types and constants of the separable linear upscaler
// ----------------------------------------------------------------------------
`default_nettype none
package slu_pkg;
	localparam int COORD_W = 10;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 24;
	localparam int OUT_W   = 16;
	localparam int REG_ADDR_W = 4;
	localparam int COORD_STEPS = 5;   // quotient bits per coordinate stage
	localparam int DIV_STEPS   = 4;   // quotient bits per channel stage

	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_STEP_X     = 2'd2;
	localparam logic [1:0] REG_STEP_Y     = 2'd3;

	localparam logic [6:0] RST_SRC_WIDTH  = 7'd64;
	localparam logic [6:0] RST_SRC_HEIGHT = 7'd64;
	localparam logic [4:0] RST_STEP_X     = 5'd1;
	localparam logic [4:0] RST_STEP_Y     = 5'd1;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic rd;        // destination read, else load
		logic outside;   // beyond the destination grid
		logic zero;      // last column or row band
	} ctl_t;
endpackage
`default_nettype wire

// ----- rtl/slu_divstage.sv -----
// ----------------------------------------------------------------------------
// slu_divstage
// a few restoring division steps, one quotient bit each
// ----------------------------------------------------------------------------
`default_nettype none
module slu_divstage #(
	parameter int RW = 5,
	parameter int K  = 4
) (
	input  logic [RW-1:0] divisor,
	input  logic [RW-1:0] rem_in,
	input  logic [K-1:0]  bits_in,
	output logic [RW-1:0] rem_out,
	output logic [K-1:0]  quo
);
	always_comb begin
		logic [RW:0]   trial;
		logic [RW-1:0] r;
		r = rem_in;
		quo = '0;
		for (int k = K - 1; k >= 0; k--) begin
			trial = {r, bits_in[k]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				quo[k] = 1'b1;
			end
			r = trial[RW-1:0];
		end
		rem_out = r;
	end
endmodule
`default_nettype wire

// ----- rtl/slu_bank.sv -----
// ----------------------------------------------------------------------------
// slu_bank
// one pixel bank, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module slu_bank #(
	parameter int AW = 10,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/separable_linear_upscaler.sv -----
// ----------------------------------------------------------------------------
// separable_linear_upscaler
// bilinear upscale of a small rgb source image held in four pixel banks
// ----------------------------------------------------------------------------
// usage
//  s_t* carries one word per item: s_tuser 0 loads a source pixel into the
//  store, 1 reads one destination pixel. m_t* returns one word per item,
//  zero channels for loads, out-of-grid and last-band reads, interpolated
//  channels (65535 = 1.0) for other reads, m_tuser set for out-of-grid ones.
//  the apb port sets source size and step factors; write it only while idle.
// timing
//  one word accepted per cycle while m_tready does not hold the pipe;
//  the result passes ten register stages. the rate is set by the four
//  parity-split pixel banks, which give the four neighbours in one read.
// reset
//  arst_n clears all stage valid bits and loads the default registers;
//  the pixel store is not cleared, a read must only use loaded pixels.
// stall
//  a low m_tready holds the output stage; bubbles further up still close,
//  and s_tready falls only once every stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "separable_linear_upscaler_assert.svh"
module separable_linear_upscaler import slu_pkg::*; #(
	parameter int MAX_SRC_WIDTH  = 64,
	parameter int MAX_SRC_HEIGHT = 64,
	parameter int MAX_STEP       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// src_col[5:0] src_row[11:6] red_in[19:12] green_in[27:20] blue_in[35:28]
	// dst_col[45:36] dst_row[55:46]
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,    // func
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // red_out[15:0] green_out[31:16] blue_out[47:32]
	output logic        m_tuser,    // outside
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	// widths that follow from the maxima
	localparam int SW   = $clog2(MAX_STEP + 1);
	localparam int WW   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int HW   = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int CW   = $clog2(MAX_SRC_WIDTH) + 1;   // spare bit keeps half index non-empty
	localparam int RWD  = $clog2(MAX_SRC_HEIGHT) + 1;
	localparam int AW   = (CW - 1) + (RWD - 1);
	localparam int GW   = WW + SW;
	localparam int GHW  = HW + SW;
	localparam int GMX  = (GW > GHW) ? GW : GHW;
	localparam int CMPW = (GMX > COORD_W) ? GMX : COORD_W;
	localparam int DDW  = 2 * SW;
	localparam int TW   = SW + CHAN_W;
	localparam int NUMW = 2 * SW + CHAN_W;
	localparam int DIVW = NUMW + 9;

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	logic [6:0] src_width_q, src_height_q;
	logic [4:0] step_x_q, step_y_q;
	logic       cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			step_x_q     <= RST_STEP_X;
			step_y_q     <= RST_STEP_Y;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_SRC_WIDTH:  src_width_q  <= pwdata[6:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[6:0];
				REG_STEP_X:     step_x_q     <= pwdata[4:0];
				REG_STEP_Y:     step_y_q     <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SRC_WIDTH:  prdata = {25'd0, src_width_q};
			REG_SRC_HEIGHT: prdata = {25'd0, src_height_q};
			REG_STEP_X:     prdata = {27'd0, step_x_q};
			REG_STEP_Y:     prdata = {27'd0, step_y_q};
			default:        prdata = '0;
		endcase
	end

	// saturated settings and grid bounds, steady while items flow
	logic [WW-1:0]  w_sat;
	logic [HW-1:0]  h_sat;
	logic [SW-1:0]  sx, sy;
	logic [GW-1:0]  grid_w, last_w;
	logic [GHW-1:0] grid_h, last_h;
	logic [DDW-1:0] area;

	assign w_sat  = (32'(src_width_q) > MAX_SRC_WIDTH) ? WW'(MAX_SRC_WIDTH) : WW'(src_width_q);
	assign h_sat  = (32'(src_height_q) > MAX_SRC_HEIGHT) ? HW'(MAX_SRC_HEIGHT)
	                                                     : HW'(src_height_q);
	assign sx     = (32'(step_x_q) > MAX_STEP) ? SW'(MAX_STEP) : SW'(step_x_q);
	assign sy     = (32'(step_y_q) > MAX_STEP) ? SW'(MAX_STEP) : SW'(step_y_q);
	assign grid_w = GW'(w_sat) * GW'(sx);
	assign last_w = GW'(w_sat - WW'(1)) * GW'(sx);
	assign grid_h = GHW'(h_sat) * GHW'(sy);
	assign last_h = GHW'(h_sat - HW'(1)) * GHW'(sy);
	assign area   = DDW'(sx) * DDW'(sy);

	// ------------------------------------------------------------------------
	// stage enables: a stage loads when empty or when the next one loads
	// ------------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10;

	assign en10 = !v_s10 || m_tready;
	assign en9  = !v_s9  || en10;
	assign en8  = !v_s8  || en9;
	assign en7  = !v_s7  || en8;
	assign en6  = !v_s6  || en7;
	assign en5  = !v_s5  || en6;
	assign en4  = !v_s4  || en5;
	assign en3  = !v_s3  || en4;
	assign en2  = !v_s2  || en3;
	assign en1  = !v_s1  || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5  <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else begin
			if (en1)  v_s1  <= s_tvalid;
			if (en2)  v_s2  <= v_s1;
			if (en3)  v_s3  <= v_s2;
			if (en4)  v_s4  <= v_s3;
			if (en5)  v_s5  <= v_s4;
			if (en6)  v_s6  <= v_s5;
			if (en7)  v_s7  <= v_s6;
			if (en8)  v_s8  <= v_s7;
			if (en9)  v_s9  <= v_s8;
			if (en10) v_s10 <= v_s9;
		end
	end

	// ------------------------------------------------------------------------
	// s1: capture word, classify against the grid
	// ------------------------------------------------------------------------
	logic [COORD_W-1:0] in_c, in_r;
	logic [COORD_W-1:0] c_s1, r_s1;
	logic [5:0]         col_s1, row_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic               ldok_s1;
	ctl_t               ctl_s1;

	assign in_c = s_tdata[45:36];
	assign in_r = s_tdata[55:46];

	always_ff @(posedge clk) begin
		if (en1) begin
			c_s1        <= in_c;
			r_s1        <= in_r;
			col_s1      <= s_tdata[5:0];
			row_s1      <= s_tdata[11:6];
			pix_s1      <= {s_tdata[19:12], s_tdata[27:20], s_tdata[35:28]};
			ldok_s1     <= (32'(s_tdata[5:0]) < MAX_SRC_WIDTH)
			            && (32'(s_tdata[11:6]) < MAX_SRC_HEIGHT);
			ctl_s1.rd   <= (s_tuser == FUNC_READ);
			ctl_s1.outside <= (CMPW'(in_c) >= CMPW'(grid_w)) || (CMPW'(in_r) >= CMPW'(grid_h));
			ctl_s1.zero <= (CMPW'(in_c) >= CMPW'(last_w)) || (CMPW'(in_r) > CMPW'(last_h));
		end
	end

	// ------------------------------------------------------------------------
	// s2, s3: column and row split by the step factors, five bits a stage
	// ------------------------------------------------------------------------
	logic [SW-1:0]          xr_a, yr_a, xr_b, yr_b;
	logic [COORD_STEPS-1:0] xq_a, yq_a, xq_b, yq_b;

	slu_divstage #(.RW(SW), .K(COORD_STEPS)) u_xdiv_a (
		.divisor(sx), .rem_in('0), .bits_in(c_s1[COORD_W-1:COORD_STEPS]),
		.rem_out(xr_a), .quo(xq_a)
	);
	slu_divstage #(.RW(SW), .K(COORD_STEPS)) u_ydiv_a (
		.divisor(sy), .rem_in('0), .bits_in(r_s1[COORD_W-1:COORD_STEPS]),
		.rem_out(yr_a), .quo(yq_a)
	);

	logic [COORD_STEPS-1:0] xq_s2, yq_s2, clo_s2, rlo_s2;
	logic [SW-1:0]          xr_s2, yr_s2;
	logic [5:0]             col_s2, row_s2;
	logic [PIX_W-1:0]       pix_s2;
	logic                   ldok_s2;
	ctl_t                   ctl_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			xq_s2   <= xq_a;
			yq_s2   <= yq_a;
			xr_s2   <= xr_a;
			yr_s2   <= yr_a;
			clo_s2  <= c_s1[COORD_STEPS-1:0];
			rlo_s2  <= r_s1[COORD_STEPS-1:0];
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			pix_s2  <= pix_s1;
			ldok_s2 <= ldok_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	slu_divstage #(.RW(SW), .K(COORD_STEPS)) u_xdiv_b (
		.divisor(sx), .rem_in(xr_s2), .bits_in(clo_s2), .rem_out(xr_b), .quo(xq_b)
	);
	slu_divstage #(.RW(SW), .K(COORD_STEPS)) u_ydiv_b (
		.divisor(sy), .rem_in(yr_s2), .bits_in(rlo_s2), .rem_out(yr_b), .quo(yq_b)
	);

	logic [COORD_W-1:0] j_s3, i_s3;
	logic [SW-1:0]      s_s3, t_s3;
	logic [5:0]         col_s3, row_s3;
	logic [PIX_W-1:0]   pix_s3;
	logic               ldok_s3;
	ctl_t               ctl_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			j_s3    <= {xq_s2, xq_b};
			i_s3    <= {yq_s2, yq_b};
			s_s3    <= xr_b;
			t_s3    <= yr_b;
			col_s3  <= col_s2;
			row_s3  <= row_s2;
			pix_s3  <= pix_s2;
			ldok_s3 <= ldok_s2;
			ctl_s3  <= ctl_s2;
		end
	end

	// ------------------------------------------------------------------------
	// s3 -> s4: four banks split by column and row parity, so the four
	// neighbours always sit in different banks; loads write here too
	// ------------------------------------------------------------------------
	logic [CW-1:0]    jj, jj1, wcol;
	logic [RWD-1:0]   rowa, rowb, wrow;
	logic             bank_we;
	logic [1:0]       wbank;
	logic [AW-1:0]    waddr;
	logic [PIX_W-1:0] bank_rd [4];

	assign jj      = CW'(j_s3);
	assign jj1     = jj + CW'(1);
	assign rowa    = RWD'(h_sat) - RWD'(1) - RWD'(i_s3);   // rows taken bottom up
	assign rowb    = rowa - RWD'(1);
	assign wcol    = CW'(col_s3);
	assign wrow    = RWD'(row_s3);
	assign bank_we = v_s3 && en4 && !ctl_s3.rd && ldok_s3;
	assign wbank   = {wrow[0], wcol[0]};
	assign waddr   = {wrow[RWD-1:1], wcol[CW-1:1]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [AW-1:0] raddr;
		assign raddr = {((b >= 2) ? rowb[RWD-1:1] : rowa[RWD-1:1]),
		                ((b % 2 == 1) ? jj[CW-1:1] : jj1[CW-1:1])};
		slu_bank #(.AW(AW), .DW(PIX_W)) u_bank (
			.clk   (clk),
			.we    (bank_we && (wbank == 2'(b))),
			.waddr (waddr),
			.wdata (pix_s3),
			.re    (en4),
			.raddr (raddr),
			.rdata (bank_rd[b])
		);
	end

	logic          jpar_s4, rpar_s4, lo_s4;
	logic [SW-1:0] ws0_s4, ws1_s4, wt0_s4, wt1_s4;
	ctl_t          ctl_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			jpar_s4 <= jj[0];
			rpar_s4 <= rowa[0];
			lo_s4   <= (t_s3 != '0);
			ws0_s4  <= sx - s_s3;
			ws1_s4  <= s_s3;
			wt0_s4  <= sy - t_s3;
			wt1_s4  <= t_s3;
			ctl_s4  <= ctl_s3;
		end
	end

	// ------------------------------------------------------------------------
	// s5: horizontal blend of both rows; the lower row weighs zero on t = 0
	// and is forced to zero then, as it may never have been loaded
	// ------------------------------------------------------------------------
	logic [PIX_W-1:0] ta_e, ta_o, tb_e, tb_o, p0, p1, p2, p3;

	assign ta_e = rpar_s4 ? bank_rd[2] : bank_rd[0];
	assign ta_o = rpar_s4 ? bank_rd[3] : bank_rd[1];
	assign tb_e = rpar_s4 ? bank_rd[0] : bank_rd[2];
	assign tb_o = rpar_s4 ? bank_rd[1] : bank_rd[3];
	assign p0   = jpar_s4 ? ta_o : ta_e;
	assign p1   = jpar_s4 ? ta_e : ta_o;
	assign p2   = !lo_s4 ? '0 : (jpar_s4 ? tb_o : tb_e);
	assign p3   = !lo_s4 ? '0 : (jpar_s4 ? tb_e : tb_o);

	logic [TW-1:0] top_s5 [3];
	logic [TW-1:0] bot_s5 [3];
	logic [SW-1:0] wt0_s5, wt1_s5;
	ctl_t          ctl_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int k = 0; k < 3; k++) begin
				top_s5[k] <= TW'(ws0_s4) * TW'(p0[PIX_W-1-CHAN_W*k -: CHAN_W])
				           + TW'(ws1_s4) * TW'(p1[PIX_W-1-CHAN_W*k -: CHAN_W]);
				bot_s5[k] <= TW'(ws0_s4) * TW'(p2[PIX_W-1-CHAN_W*k -: CHAN_W])
				           + TW'(ws1_s4) * TW'(p3[PIX_W-1-CHAN_W*k -: CHAN_W]);
			end
			wt0_s5 <= wt0_s4;
			wt1_s5 <= wt1_s4;
			ctl_s5 <= ctl_s4;
		end
	end

	// ------------------------------------------------------------------------
	// s6: vertical blend
	// ------------------------------------------------------------------------
	logic [NUMW-1:0] num_s6 [3];
	ctl_t            ctl_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			for (int k = 0; k < 3; k++) begin
				num_s6[k] <= NUMW'(wt0_s5) * NUMW'(top_s5[k])
				           + NUMW'(wt1_s5) * NUMW'(bot_s5[k]);
			end
			ctl_s6 <= ctl_s5;
		end
	end

	// ------------------------------------------------------------------------
	// s7..s10: num*257 / (sx*sy), four quotient bits a stage; the top part
	// of the dividend is already below the divisor, so 16 bits suffice
	// ------------------------------------------------------------------------
	logic [DDW-1:0]   rem_s7 [3], rem_s8 [3], rem_s9 [3];
	logic [OUT_W-1:0] work_s7 [3], work_s8 [3], work_s9 [3];
	logic [OUT_W-1:0] dat_s10 [3];
	ctl_t             ctl_s7, ctl_s8, ctl_s9, ctl_s10;

	for (genvar k = 0; k < 3; k++) begin : g_chan
		logic [DIVW-1:0]      dvd;
		logic [DDW-1:0]       r7, r8, r9, r10;
		logic [DIV_STEPS-1:0] q7, q8, q9, q10;

		assign dvd = (DIVW'(num_s6[k]) << 8) + DIVW'(num_s6[k]);

		slu_divstage #(.RW(DDW), .K(DIV_STEPS)) u_d7 (
			.divisor(area), .rem_in(dvd[DDW+OUT_W-1:OUT_W]),
			.bits_in(dvd[OUT_W-1 -: DIV_STEPS]), .rem_out(r7), .quo(q7)
		);
		slu_divstage #(.RW(DDW), .K(DIV_STEPS)) u_d8 (
			.divisor(area), .rem_in(rem_s7[k]),
			.bits_in(work_s7[k][OUT_W-1 -: DIV_STEPS]), .rem_out(r8), .quo(q8)
		);
		slu_divstage #(.RW(DDW), .K(DIV_STEPS)) u_d9 (
			.divisor(area), .rem_in(rem_s8[k]),
			.bits_in(work_s8[k][OUT_W-1 -: DIV_STEPS]), .rem_out(r9), .quo(q9)
		);
		slu_divstage #(.RW(DDW), .K(DIV_STEPS)) u_d10 (
			.divisor(area), .rem_in(rem_s9[k]),
			.bits_in(work_s9[k][OUT_W-1 -: DIV_STEPS]), .rem_out(r10), .quo(q10)
		);

		// consumed dividend bits are replaced by quotient bits from the right
		always_ff @(posedge clk) begin
			if (en7) begin
				rem_s7[k]  <= r7;
				work_s7[k] <= {dvd[OUT_W-DIV_STEPS-1:0], q7};
			end
			if (en8) begin
				rem_s8[k]  <= r8;
				work_s8[k] <= {work_s7[k][OUT_W-DIV_STEPS-1:0], q8};
			end
			if (en9) begin
				rem_s9[k]  <= r9;
				work_s9[k] <= {work_s8[k][OUT_W-DIV_STEPS-1:0], q9};
			end
			if (en10) begin
				// loads, out-of-grid reads and the last band give zero
				dat_s10[k] <= (!ctl_s9.rd || ctl_s9.outside || ctl_s9.zero) ? '0
				            : {work_s9[k][OUT_W-DIV_STEPS-1:0], q10};
			end
		end
		assign m_tdata[OUT_W*k +: OUT_W] = dat_s10[k];
	end

	always_ff @(posedge clk) begin
		if (en7)  ctl_s7  <= ctl_s6;
		if (en8)  ctl_s8  <= ctl_s7;
		if (en9)  ctl_s9  <= ctl_s8;
		if (en10) ctl_s10 <= ctl_s9;
	end

	assign m_tvalid = v_s10;
	assign m_tuser  = ctl_s10.rd && ctl_s10.outside;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	// an out-of-grid flag always comes with zero channels
	`SLU_ASSERT_IMPL(a_outside_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	// the input side stalls only when the whole pipe is full and blocked
	`SLU_ASSERT_IMPL(a_stall_full, clk, arst_n, !s_tready, v_s1 && v_s5 && v_s9 && v_s10 && !m_tready)
	// a word leaving the last divide stage always shows at the output
	`SLU_ASSERT_NEXT(a_out_load, clk, arst_n, v_s9 && en10, m_tvalid)
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// separable_linear_upscaler testbench
// loads source pixels and reads destination pixels over several size and
// step settings, predicts each result word and checks it field by field
// ----------------------------------------------------------------------------
`default_nettype none

// expected result of one item
typedef struct {
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic        outside;
} pix_result_t;

class upscale_scoreboard;
	logic [23:0] pixels [4096];
	bit          loaded [4096];
	logic [6:0]  width_reg, height_reg;
	logic [4:0]  stepx_reg, stepy_reg;
	pix_result_t pending_q [$];
	int          errors;
	int          n_loads, n_reads, n_outside;

	function new();
		width_reg  = slu_pkg::RST_SRC_WIDTH;
		height_reg = slu_pkg::RST_SRC_HEIGHT;
		stepx_reg  = slu_pkg::RST_STEP_X;
		stepy_reg  = slu_pkg::RST_STEP_Y;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			slu_pkg::REG_SRC_WIDTH:  width_reg  = val[6:0];
			slu_pkg::REG_SRC_HEIGHT: height_reg = val[6:0];
			slu_pkg::REG_STEP_X:     stepx_reg  = val[4:0];
			default:                 stepy_reg  = val[4:0];
		endcase
	endfunction

	function void eff(output int w, output int h, output int sx, output int sy);
		w  = width_reg > 64 ? 64 : width_reg;
		h  = height_reg > 64 ? 64 : height_reg;
		sx = stepx_reg > 16 ? 16 : stepx_reg;
		sy = stepy_reg > 16 ? 16 : stepy_reg;
	endfunction

	// store entries that a read at (c, r) would use
	function void taps(int c, int r, ref int idx_q[$]);
		int w, h, sx, sy, j, i, t, rowa;
		eff(w, h, sx, sy);
		idx_q.delete();
		if (c >= w*sx || r >= h*sy) return;
		if (c >= (w-1)*sx || r > (h-1)*sy) return;
		j = c / sx; i = r / sy; t = r % sy;
		rowa = h - 1 - i;
		idx_q.push_back(rowa*64 + j);
		idx_q.push_back(rowa*64 + j + 1);
		if (t != 0 && rowa >= 1) begin
			idx_q.push_back((rowa-1)*64 + j);
			idx_q.push_back((rowa-1)*64 + j + 1);
		end
	endfunction

	function int unsigned blend(int sx, int sy, int s, int t, logic [7:0] a,
			logic [7:0] b, logic [7:0] cc, logic [7:0] d);
		int unsigned top, bot, num;
		top = (sx-s)*a + s*b;
		bot = (sx-s)*cc + s*d;
		num = (sy-t)*top + t*bot;
		num = (num * 257) / (sx*sy);
		return num > 65535 ? 65535 : num;
	endfunction

	function void note_input(logic func, logic [55:0] d);
		pix_result_t e;
		int w, h, sx, sy, c, r, j, s, i, t, rowa;
		logic [23:0] p0, p1, p2, p3;
		e = '{16'd0, 16'd0, 16'd0, 1'b0};
		if (func == slu_pkg::FUNC_LOAD) begin
			pixels[d[11:6]*64 + d[5:0]] = {d[19:12], d[27:20], d[35:28]};
			loaded[d[11:6]*64 + d[5:0]] = 1'b1;
			n_loads++;
		end else begin
			n_reads++;
			eff(w, h, sx, sy);
			c = d[45:36]; r = d[55:46];
			if (c >= w*sx || r >= h*sy) begin
				e.outside = 1'b1;
				n_outside++;
			end else if (!(c >= (w-1)*sx || r > (h-1)*sy)) begin
				j = c / sx; s = c % sx; i = r / sy; t = r % sy;
				rowa = h - 1 - i;
				p0 = pixels[rowa*64 + j];
				p1 = pixels[rowa*64 + j + 1];
				p2 = '0; p3 = '0;
				if (t != 0 && rowa >= 1) begin
					p2 = pixels[(rowa-1)*64 + j];
					p3 = pixels[(rowa-1)*64 + j + 1];
				end
				e.red   = 16'(blend(sx, sy, s, t, p0[23:16], p1[23:16], p2[23:16], p3[23:16]));
				e.green = 16'(blend(sx, sy, s, t, p0[15:8], p1[15:8], p2[15:8], p3[15:8]));
				e.blue  = 16'(blend(sx, sy, s, t, p0[7:0], p1[7:0], p2[7:0], p3[7:0]));
			end
		end
		pending_q.push_back(e);
	endfunction

	function void check(logic [47:0] d, logic outside);
		pix_result_t e;
		if (pending_q.size() == 0) begin
			$error("result word with nothing expected");
			errors++;
			return;
		end
		e = pending_q.pop_front();
		if (d[15:0] !== e.red) begin
			$error("red_out expected %0d got %0d", e.red, d[15:0]); errors++;
		end
		if (d[31:16] !== e.green) begin
			$error("green_out expected %0d got %0d", e.green, d[31:16]); errors++;
		end
		if (d[47:32] !== e.blue) begin
			$error("blue_out expected %0d got %0d", e.blue, d[47:32]); errors++;
		end
		if (outside !== e.outside) begin
			$error("outside expected %0d got %0d", e.outside, outside); errors++;
		end
	endfunction
endclass

module testbench;
	import slu_pkg::*;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [55:0] s_tdata;     // src_col src_row red green blue dst_col dst_row
	logic        m_tvalid, m_tready, m_tuser;
	logic [47:0] m_tdata;     // red green blue
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;

	upscale_scoreboard sb;
	bit idle_on;          // random gaps on both sides
	bit hold_req;         // ask the receiver for one long hold-off
	int quiet_cycles;
	int phases_run;

	separable_linear_upscaler u_top (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= FUNC_LOAD;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < 18);
				@(posedge clk);
			end
		end
	end

	// result monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000) begin
			$display("watchdog: no progress for 3000 cycles");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one word into the input stream, with a random gap before it
	task automatic push_word(logic func, logic [55:0] d);
		while (idle_on && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(func, d);
	endtask

	task automatic load_pixel(int col, int row, logic [23:0] rgb);
		logic [55:0] d;
		d = 56'({$urandom(), $urandom()});   // dst fields are don't-care for loads
		d[5:0] = 6'(col); d[11:6] = 6'(row);
		d[19:12] = rgb[23:16]; d[27:20] = rgb[15:8]; d[35:28] = rgb[7:0];
		push_word(FUNC_LOAD, d);
	endtask

	// read a destination pixel, loading any source pixel it needs first
	task automatic read_pixel(int c, int r);
		int taps_q[$];
		logic [55:0] d;
		sb.taps(c, r, taps_q);
		foreach (taps_q[k])
			if (!sb.loaded[taps_q[k]])
				load_pixel(taps_q[k] % 64, taps_q[k] / 64, 24'($urandom()));
		d = 56'({$urandom(), $urandom()});
		d[45:36] = 10'(c); d[55:46] = 10'(r);
		push_word(FUNC_READ, d);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (14) @(posedge clk);   // ten pipeline stages plus margin
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// upper bits random, so register masking is exercised too
	function automatic logic [31:0] reg_val(int v, int bits);
		logic [31:0] x;
		x = $urandom();
		x = (x << bits) | v;
		return x;
	endfunction

	task automatic run_phase(int w, int h, int sx, int sy, int n);
		int ew, eh, esx, esy, c, r;
		wait_drain();
		apb_write(REG_SRC_WIDTH,  reg_val(w, 7));
		apb_write(REG_SRC_HEIGHT, reg_val(h, 7));
		apb_write(REG_STEP_X,     reg_val(sx, 5));
		apb_write(REG_STEP_Y,     reg_val(sy, 5));
		phases_run++;
		sb.eff(ew, eh, esx, esy);
		repeat (n) begin
			if ($urandom_range(99) < 25) begin
				if ($urandom_range(1))
					load_pixel($urandom_range(63), $urandom_range(63), 24'($urandom()));
				else
					load_pixel($urandom_range(ew > 0 ? ew-1 : 0),
						$urandom_range(eh > 0 ? eh-1 : 0), 24'($urandom()));
			end else if ($urandom_range(99) < 85) begin
				c = $urandom_range(ew*esx + 1); r = $urandom_range(eh*esy + 1);
				read_pixel(c > 1023 ? 1023 : c, r > 1023 ? 1023 : r);
			end else begin
				read_pixel($urandom_range(1023), $urandom_range(1023));
			end
		end
	endtask

	initial begin
		sb = new();
		idle_on = 1;
		hold_req = 0;
		quiet_cycles = 0;
		phases_run = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset registers: corners, extremes, band and grid edges
		load_pixel(0, 0, 24'h000000);
		load_pixel(63, 63, 24'hffffff);
		load_pixel(0, 63, 24'hff00ff);
		load_pixel(1, 63, 24'h00ff00);
		load_pixel(62, 62, 24'h123456);
		read_pixel(0, 0);
		read_pixel(62, 1);
		read_pixel(63, 0);          // last column band
		read_pixel(63, 63);
		read_pixel(64, 0);          // beyond the grid
		read_pixel(0, 64);
		read_pixel(1023, 1023);
		read_pixel(30, 40);

		// small grid with steps of 3 and 2, for mixed interpolation phases
		run_phase(3, 3, 3, 2, 10);
		read_pixel(5, 3);           // inside the grid, before the last column band
		read_pixel(4, 5);           // row band after the last source row
		read_pixel(1, 1);

		// random phases, extremes included
		idle_on = 0;                // stretch with no idling at all
		run_phase(4, 3, 3, 2, 40);
		idle_on = 1;
		run_phase(2, 2, 1, 1, 30);
		hold_req = 1;               // receiver holds off while reads keep coming
		repeat (30) read_pixel($urandom_range(2), $urandom_range(2));
		run_phase(5, 4, 16, 16, 40);
		run_phase(127, 127, 31, 31, 30);  // saturates to the maxima
		run_phase(0, 5, 2, 2, 15);        // empty grid, every read outside
		run_phase(3, 6, 0, 3, 15);
		run_phase(6, 2, 16, 1, 30);
		run_phase(2, 64, 1, 16, 30);
		run_phase(64, 64, 1, 1, 30);
		run_phase(8, 8, 5, 7, 40);

		wait_drain();
		$display("covered %0d loads and %0d reads (%0d outside) over %0d settings",
			sb.n_loads, sb.n_reads, sb.n_outside, phases_run + 1);
		$display("with random gaps, one long output stall and saturated registers");
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/slu_pkg.sv
rtl/slu_divstage.sv
rtl/slu_bank.sv
rtl/separable_linear_upscaler.sv
tb/testbench.sv
